[rtl/vac_pkg.sv]
// ----------------------------------------------------------------------------
// vac_pkg
// Shared constants and types of the visual approach controller.
// ----------------------------------------------------------------------------
package vac_pkg;

  localparam int IMAGE_WIDTH  = 640;
  localparam int FOUND_FRAMES = 3;

  localparam logic [2:0] REG_STOP_HEIGHT      = 3'd0;
  localparam logic [2:0] REG_TURN_GAIN        = 3'd1;
  localparam logic [2:0] REG_SLEW_STEP        = 3'd2;
  localparam logic [2:0] REG_SEARCH_TURN_RATE = 3'd3;
  localparam logic [2:0] REG_DRIVE_SPEED      = 3'd4;
  localparam logic [2:0] REG_NARROW_WINDOW    = 3'd5;
  localparam logic [2:0] REG_WIDE_WINDOW      = 3'd6;
  localparam logic [2:0] REG_LOST_LIMIT       = 3'd7;

  localparam logic [9:0]  RST_STOP_HEIGHT      = 10'd400;
  localparam logic [15:0] RST_TURN_GAIN        = 16'd1049;
  localparam logic [14:0] RST_SLEW_STEP        = 15'd205;
  localparam logic [14:0] RST_SEARCH_TURN_RATE = 15'd1434;
  localparam logic [14:0] RST_DRIVE_SPEED      = 15'd3277;
  localparam logic [9:0]  RST_NARROW_WINDOW    = 10'd10;
  localparam logic [9:0]  RST_WIDE_WINDOW      = 10'd80;
  localparam logic [7:0]  RST_LOST_LIMIT       = 8'd5;

  typedef struct packed {
    logic [9:0]  stop_height;
    logic [15:0] turn_gain;
    logic [14:0] slew_step;
    logic [14:0] search_turn_rate;
    logic [14:0] drive_speed;
    logic [9:0]  narrow_window;
    logic [9:0]  wide_window;
    logic [7:0]  lost_limit;
  } cfg_t;

  typedef struct packed {
    logic               target_found;
    logic [9:0]         target_center_x;
    logic [9:0]         box_height;
    logic signed [15:0] avoid_direction;
  } item_t;

  typedef struct packed {
    logic signed [15:0] turn_rate;
    logic [14:0]        forward_speed;
    logic signed [15:0] crab_direction;
    logic               goal_reached;
  } res_t;

endpackage

[rtl/vac_cfg_regs.sv]
// ----------------------------------------------------------------------------
// vac_cfg_regs
// Configuration register file, written by index, no read-back.
// ----------------------------------------------------------------------------
module vac_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_wdata,
  output vac_pkg::cfg_t cfg
);

  vac_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_height      <= vac_pkg::RST_STOP_HEIGHT;
      cfg_r.turn_gain        <= vac_pkg::RST_TURN_GAIN;
      cfg_r.slew_step        <= vac_pkg::RST_SLEW_STEP;
      cfg_r.search_turn_rate <= vac_pkg::RST_SEARCH_TURN_RATE;
      cfg_r.drive_speed      <= vac_pkg::RST_DRIVE_SPEED;
      cfg_r.narrow_window    <= vac_pkg::RST_NARROW_WINDOW;
      cfg_r.wide_window      <= vac_pkg::RST_WIDE_WINDOW;
      cfg_r.lost_limit       <= vac_pkg::RST_LOST_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vac_pkg::REG_STOP_HEIGHT:      cfg_r.stop_height      <= cfg_wdata[9:0];
        vac_pkg::REG_TURN_GAIN:        cfg_r.turn_gain        <= cfg_wdata;
        vac_pkg::REG_SLEW_STEP:        cfg_r.slew_step        <= cfg_wdata[14:0];
        vac_pkg::REG_SEARCH_TURN_RATE: cfg_r.search_turn_rate <= cfg_wdata[14:0];
        vac_pkg::REG_DRIVE_SPEED:      cfg_r.drive_speed      <= cfg_wdata[14:0];
        vac_pkg::REG_NARROW_WINDOW:    cfg_r.narrow_window    <= cfg_wdata[9:0];
        vac_pkg::REG_WIDE_WINDOW:      cfg_r.wide_window      <= cfg_wdata[9:0];
        vac_pkg::REG_LOST_LIMIT:       cfg_r.lost_limit       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/vac_ctrl.sv]
// ----------------------------------------------------------------------------
// vac_ctrl
// Per-frame controller state and the single-pass update that makes one
// result from one item.
// ----------------------------------------------------------------------------
module vac_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  vac_pkg::cfg_t cfg,
  input  vac_pkg::item_t item,
  input  logic          step,
  output vac_pkg::res_t res
);

  localparam logic signed [11:0] IMG_W = 12'(vac_pkg::IMAGE_WIDTH);
  localparam logic [7:0]         FOUND_LIM = 8'(vac_pkg::FOUND_FRAMES);

  logic signed [15:0] prev_turn_r, prev_turn_nxt;
  logic               centred_r, centred_nxt;
  logic               prev_centred_r, prev_centred_nxt;
  logic [7:0]         lost_r, lost_nxt;
  logic [7:0]         seen_r, seen_nxt;
  logic               ccw_r, ccw_nxt;
  logic signed [15:0] turn_r, turn_nxt;
  logic [14:0]        fwd_r, fwd_nxt;
  logic signed [15:0] crab_r, crab_nxt;
  logic               goal;

  logic [7:0]         lost_inc, seen_inc;
  logic signed [11:0] e2;
  logic [11:0]        mag2, wide2, narrow2;
  logic signed [28:0] prod, rnd;
  logic signed [19:0] t_raw, lo, hi, t_clamp;
  logic signed [15:0] t_sat;
  logic               cen_keep;

  assign lost_inc = (lost_r == 8'hFF) ? lost_r : lost_r + 8'd1;
  assign seen_inc = (seen_r == 8'hFF) ? seen_r : seen_r + 8'd1;

  assign e2      = IMG_W - $signed({1'b0, item.target_center_x, 1'b0});
  assign mag2    = e2[11] ? 12'(-e2) : 12'(e2);
  assign wide2   = {1'b0, cfg.wide_window, 1'b0};
  assign narrow2 = {1'b0, cfg.narrow_window, 1'b0};

  assign prod  = e2 * $signed({1'b0, cfg.turn_gain});
  assign rnd   = prod + 29'sd256;
  assign t_raw = rnd[28:9];
  assign lo    = 20'(prev_turn_r) - $signed({5'b0, cfg.slew_step});
  assign hi    = 20'(prev_turn_r) + $signed({5'b0, cfg.slew_step});

  always_comb begin
    t_clamp = t_raw;
    if (t_clamp < lo) t_clamp = lo;
    if (t_clamp > hi) t_clamp = hi;
    if (t_clamp > 20'sd32767) begin
      t_sat = 16'sh7FFF;
    end else if (t_clamp < -20'sd32768) begin
      t_sat = 16'sh8000;
    end else begin
      t_sat = t_clamp[15:0];
    end
  end

  assign cen_keep = centred_r && !(mag2 > wide2);

  always_comb begin
    prev_turn_nxt    = prev_turn_r;
    centred_nxt      = centred_r;
    prev_centred_nxt = prev_centred_r;
    lost_nxt         = lost_r;
    seen_nxt         = seen_r;
    ccw_nxt          = ccw_r;
    turn_nxt         = turn_r;
    fwd_nxt          = fwd_r;
    crab_nxt         = crab_r;
    goal             = 1'b0;
    if (!item.target_found) begin
      lost_nxt = lost_inc;
      seen_nxt = 8'd0;
      if (lost_inc > cfg.lost_limit) begin
        turn_nxt = ccw_r ? $signed({1'b0, cfg.search_turn_rate})
                         : -$signed({1'b0, cfg.search_turn_rate});
        fwd_nxt  = 15'd0;
      end
    end else if (item.avoid_direction != 16'sd0) begin
      fwd_nxt  = cfg.drive_speed;
      crab_nxt = item.avoid_direction;
      turn_nxt = 16'sd0;
    end else begin
      crab_nxt = 16'sd0;
      lost_nxt = 8'd0;
      seen_nxt = seen_inc;
      ccw_nxt  = !e2[11];
      if (cen_keep || (mag2 < narrow2)) begin
        turn_nxt = 16'sd0;
        if ((item.box_height > cfg.stop_height) && (seen_inc > FOUND_LIM)) begin
          fwd_nxt     = 15'd0;
          centred_nxt = 1'b0;
          goal        = 1'b1;
        end else begin
          centred_nxt      = 1'b1;
          fwd_nxt          = cfg.drive_speed;
          prev_turn_nxt    = 16'sd0;
          prev_centred_nxt = 1'b1;
        end
      end else begin
        centred_nxt      = 1'b0;
        prev_centred_nxt = 1'b0;
        if (prev_centred_r) begin
          turn_nxt = 16'sd0;
          fwd_nxt  = 15'd0;
        end else begin
          turn_nxt = t_sat;
          fwd_nxt  = 15'd0;
        end
        prev_turn_nxt = prev_centred_r ? 16'sd0 : t_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_turn_r    <= '0;
      centred_r      <= 1'b0;
      prev_centred_r <= 1'b0;
      lost_r         <= '0;
      seen_r         <= '0;
      ccw_r          <= 1'b0;
      turn_r         <= '0;
      fwd_r          <= '0;
      crab_r         <= '0;
    end else if (step) begin
      prev_turn_r    <= prev_turn_nxt;
      centred_r      <= centred_nxt;
      prev_centred_r <= prev_centred_nxt;
      lost_r         <= lost_nxt;
      seen_r         <= seen_nxt;
      ccw_r          <= ccw_nxt;
      turn_r         <= turn_nxt;
      fwd_r          <= fwd_nxt;
      crab_r         <= crab_nxt;
    end
  end

  assign res.turn_rate      = turn_nxt;
  assign res.forward_speed  = fwd_nxt;
  assign res.crab_direction = crab_nxt;
  assign res.goal_reached   = goal;

endmodule

[rtl/visual_approach_controller_core.sv]
// ----------------------------------------------------------------------------
// visual_approach_controller_core
// An item accepted at one edge goes into the input register; the single-pass
// update then writes its result into the output register once that is free.
// One item per cycle while the output is not stalled, set by the state update loop.
// Synchronous active-low reset clears state and valids and loads the
// register defaults.
// ----------------------------------------------------------------------------
module visual_approach_controller_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_target_found,
  input  logic [9:0]         in_target_center_x,
  input  logic [9:0]         in_box_height,
  input  logic signed [15:0] in_avoid_direction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_turn_rate,
  output logic [14:0]        out_forward_speed,
  output logic signed [15:0] out_crab_direction,
  output logic               out_goal_reached
);

  vac_pkg::cfg_t  cfg;
  vac_pkg::item_t item_r;
  vac_pkg::res_t  res, res_r;
  logic           s1_valid_r;
  logic           out_valid_r;
  logic           out_free;
  logic           step;

  assign out_free = !out_valid_r || out_ready;
  assign step     = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  vac_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  vac_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (item_r),
    .step  (step),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (out_free) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.target_found    <= in_target_found;
      item_r.target_center_x <= in_target_center_x;
      item_r.box_height      <= in_box_height;
      item_r.avoid_direction <= in_avoid_direction;
    end
    if (step) res_r <= res;
  end

  assign out_valid          = out_valid_r;
  assign out_turn_rate      = res_r.turn_rate;
  assign out_forward_speed  = res_r.forward_speed;
  assign out_crab_direction = res_r.crab_direction;
  assign out_goal_reached   = res_r.goal_reached;

endmodule

[rtl/vac_checker.sv]
// ----------------------------------------------------------------------------
// vac_checker
// Port-level checks of the visual approach controller, bound to the top.
// ----------------------------------------------------------------------------
module vac_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_turn_rate,
  input logic [14:0]        out_forward_speed,
  input logic signed [15:0] out_crab_direction,
  input logic               out_goal_reached
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_turn_rate)
      && $stable(out_forward_speed) && $stable(out_goal_reached))
    else $error("stalled item changed");

  // goal frame stops the robot
  a_goal_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_goal_reached |-> out_turn_rate == 16'sd0
      && out_forward_speed == 15'd0)
    else $error("goal item not stopped");

  a_goal_crab: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_goal_reached |-> out_crab_direction == 16'sd0)
    else $error("goal item with crab");

  // empty result register never blocks input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output empty");

endmodule

bind visual_approach_controller_core vac_checker u_vac_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_turn_rate      (out_turn_rate),
  .out_forward_speed  (out_forward_speed),
  .out_crab_direction (out_crab_direction),
  .out_goal_reached   (out_goal_reached)
);

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for visual_approach_controller_core. Camera frames go in
// over a valid/ready channel, each accepted frame is run through a local
// model of the steering logic, and every command item coming out is compared
// field by field against the oldest pending prediction. Directed frames cover
// field extremes, obstacle crabbing, the lost-target spin in both senses, the
// centred hysteresis, goal detection, inverted windows and counter
// saturation, and one long output hold-off; random phases then re-program all
// registers and run approach episodes mixed with noise, mostly under random idling.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT_CYCLES = 200000;
  localparam int IMG_W        = 640;
  localparam int FOUND_MIN    = 3;
  localparam int PRINT_CAP    = 30;

  typedef enum logic {SENSE_CW, SENSE_CCW} sense_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic               in_target_found;
  logic [9:0]         in_target_center_x;
  logic [9:0]         in_box_height;
  logic signed [15:0] in_avoid_direction;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_turn_rate;
  logic [14:0]        out_forward_speed;
  logic signed [15:0] out_crab_direction;
  logic               out_goal_reached;

  // local copy of the registers and the steering state
  vac_pkg::cfg_t cfg;
  int            prev_turn;
  logic          centred;
  logic          prev_centred;
  logic [7:0]    lost_cnt;
  logic [7:0]    seen_cnt;
  sense_t        sense;
  int            turn_cmd;
  int            fwd_cmd;
  int            crab_cmd;

  vac_pkg::res_t pending_cmds[$];

  int  fail_count;
  int  cycle_count;
  int  frames_sent;
  int  cmds_checked;
  int  goals_seen;
  int  spins_predicted;
  int  in_stalls;
  int  hold_req;
  int  stall_left;
  bit  idle_on;

  visual_approach_controller_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_target_found    (in_target_found),
    .in_target_center_x (in_target_center_x),
    .in_box_height      (in_box_height),
    .in_avoid_direction (in_avoid_direction),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_turn_rate      (out_turn_rate),
    .out_forward_speed  (out_forward_speed),
    .out_crab_direction (out_crab_direction),
    .out_goal_reached   (out_goal_reached)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d commands pending", cycle_count,
               pending_cmds.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_count < PRINT_CAP)
      $display("mismatch %s: got %0d, want %0d (command %0d, t=%0t)", what, got, want,
               cmds_checked, $realtime);
    fail_count++;
  endtask

  function automatic void reset_model();
    cfg.stop_height      = 10'd400;
    cfg.turn_gain        = 16'd1049;
    cfg.slew_step        = 15'd205;
    cfg.search_turn_rate = 15'd1434;
    cfg.drive_speed      = 15'd3277;
    cfg.narrow_window    = 10'd10;
    cfg.wide_window      = 10'd80;
    cfg.lost_limit       = 8'd5;
    prev_turn    = 0;
    centred      = 1'b0;
    prev_centred = 1'b0;
    lost_cnt     = 8'd0;
    seen_cnt     = 8'd0;
    sense        = SENSE_CW;
    turn_cmd     = 0;
    fwd_cmd      = 0;
    crab_cmd     = 0;
  endfunction

  function automatic vac_pkg::res_t predict_commands(input vac_pkg::item_t it);
    vac_pkg::res_t r;
    int     e2;
    int     mag2;
    longint prod;
    longint t;
    longint lo;
    longint hi;
    logic   goal;
    goal = 1'b0;
    if (!it.target_found) begin
      if (lost_cnt != 8'hFF) lost_cnt++;
      seen_cnt = 8'd0;
      if (lost_cnt > cfg.lost_limit) begin
        turn_cmd = (sense == SENSE_CCW) ? int'(cfg.search_turn_rate)
                                        : -int'(cfg.search_turn_rate);
        fwd_cmd = 0;
        spins_predicted++;
      end
    end else if (it.avoid_direction != 16'sd0) begin
      fwd_cmd  = int'(cfg.drive_speed);
      crab_cmd = int'(it.avoid_direction);
      turn_cmd = 0;
    end else begin
      crab_cmd = 0;
      lost_cnt = 8'd0;
      if (seen_cnt != 8'hFF) seen_cnt++;
      e2   = IMG_W - 2 * int'(it.target_center_x);
      mag2 = (e2 < 0) ? -e2 : e2;
      sense = (e2 < 0) ? SENSE_CW : SENSE_CCW;
      if (mag2 > 2 * int'(cfg.wide_window)) centred = 1'b0;
      if (centred || mag2 < 2 * int'(cfg.narrow_window)) begin
        centred  = 1'b1;
        turn_cmd = 0;
        if (it.box_height > cfg.stop_height && int'(seen_cnt) > FOUND_MIN) begin
          fwd_cmd = 0;
          centred = 1'b0;
          goal    = 1'b1;
        end else begin
          fwd_cmd = int'(cfg.drive_speed);
        end
      end else begin
        prod = longint'(e2) * longint'(cfg.turn_gain);
        t    = (prod + 256) >>> 9;
        lo   = longint'(prev_turn) - longint'(cfg.slew_step);
        hi   = longint'(prev_turn) + longint'(cfg.slew_step);
        if (t < lo) t = lo;
        if (t > hi) t = hi;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        turn_cmd = int'(t);
        fwd_cmd  = 0;
      end
      // goal frame leaves the history untouched
      if (!goal) begin
        if (prev_centred && !centred) begin
          turn_cmd = 0;
          fwd_cmd  = 0;
        end
        prev_turn    = turn_cmd;
        prev_centred = centred;
      end
    end
    r.turn_rate      = turn_cmd[15:0];
    r.forward_speed  = fwd_cmd[14:0];
    r.crab_direction = crab_cmd[15:0];
    r.goal_reached   = goal;
    return r;
  endfunction

  function automatic vac_pkg::item_t frame(input logic found, input int cx, input int h,
                                           input int av);
    vac_pkg::item_t it;
    it.target_found    = found;
    it.target_center_x = cx[9:0];
    it.box_height      = h[9:0];
    it.avoid_direction = av[15:0];
    return it;
  endfunction

  task automatic send_frame(input vac_pkg::item_t it);
    int gap;
    vac_pkg::res_t pred;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid           = 1'b1;
    in_target_found    = it.target_found;
    in_target_center_x = it.target_center_x;
    in_box_height      = it.box_height;
    in_avoid_direction = it.avoid_direction;
    @(posedge clk);
    while (!in_ready) begin
      in_stalls++;
      @(posedge clk);
    end
    pred = predict_commands(it);
    pending_cmds.insert(pending_cmds.size(), pred);
    frames_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      vac_pkg::REG_STOP_HEIGHT:      cfg.stop_height      = val[9:0];
      vac_pkg::REG_TURN_GAIN:        cfg.turn_gain        = val[15:0];
      vac_pkg::REG_SLEW_STEP:        cfg.slew_step        = val[14:0];
      vac_pkg::REG_SEARCH_TURN_RATE: cfg.search_turn_rate = val[14:0];
      vac_pkg::REG_DRIVE_SPEED:      cfg.drive_speed      = val[14:0];
      vac_pkg::REG_NARROW_WINDOW:    cfg.narrow_window    = val[9:0];
      vac_pkg::REG_WIDE_WINDOW:      cfg.wide_window      = val[9:0];
      vac_pkg::REG_LOST_LIMIT:       cfg.lost_limit       = val[7:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_value(input logic [2:0] idx);
    int mode;
    mode = $urandom_range(0, 5);
    if (mode == 0) return 16'h0000;
    if (mode == 1) return 16'hFFFF;
    if (mode == 2) return 16'($urandom());
    case (idx)
      vac_pkg::REG_STOP_HEIGHT:      return 16'($urandom_range(50, 800));
      vac_pkg::REG_TURN_GAIN:        return 16'($urandom_range(100, 8000));
      vac_pkg::REG_SLEW_STEP:        return 16'($urandom_range(50, 4000));
      vac_pkg::REG_SEARCH_TURN_RATE: return 16'($urandom_range(100, 8000));
      vac_pkg::REG_DRIVE_SPEED:      return 16'($urandom_range(100, 8000));
      vac_pkg::REG_NARROW_WINDOW:    return 16'($urandom_range(0, 40));
      vac_pkg::REG_WIDE_WINDOW:      return 16'($urandom_range(20, 200));
      default:                       return 16'($urandom_range(0, 8));
    endcase
  endfunction

  task automatic write_all_regs(input logic [15:0] val);
    write_reg(vac_pkg::REG_STOP_HEIGHT, val);
    write_reg(vac_pkg::REG_TURN_GAIN, val);
    write_reg(vac_pkg::REG_SLEW_STEP, val);
    write_reg(vac_pkg::REG_SEARCH_TURN_RATE, val);
    write_reg(vac_pkg::REG_DRIVE_SPEED, val);
    write_reg(vac_pkg::REG_NARROW_WINDOW, val);
    write_reg(vac_pkg::REG_WIDE_WINDOW, val);
    write_reg(vac_pkg::REG_LOST_LIMIT, val);
  endtask

  task automatic send_lost(input int n);
    repeat (n)
      send_frame(frame(1'b0, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 65535)));
  endtask

  // optional lost stretch, then found frames converging on the centre with a growing box
  task automatic run_episode();
    int cx;
    int h;
    int av;
    int n_found;
    if ($urandom_range(0, 2) == 0) send_lost($urandom_range(1, 12));
    cx      = $urandom_range(0, 1023);
    h       = $urandom_range(0, 400);
    n_found = $urandom_range(4, 24);
    repeat (n_found) begin
      cx = cx + (320 - cx) / 2 + int'($urandom_range(0, 16)) - 8;
      if (cx < 0) cx = 0;
      if (cx > 1023) cx = 1023;
      h = h + int'($urandom_range(0, 80));
      if (h > 1023) h = 1023;
      av = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 65535) : 0;
      send_frame(frame(1'b1, cx, h, av));
    end
  endtask

  task automatic test_reset_defaults();
    send_frame(frame(1'b0, 1023, 1023, 32767));
    send_frame(frame(1'b1, 0, 0, 0));
    send_frame(frame(1'b1, 1023, 1023, 0));
    send_frame(frame(1'b1, 1023, 512, 0));
    send_frame(frame(1'b1, 320, 0, 0));
    send_frame(frame(1'b1, 360, 100, 0));
    send_frame(frame(1'b1, 410, 100, 0));
    send_frame(frame(1'b1, 320, 1023, 0));
    send_frame(frame(1'b1, 319, 1023, 0));
    send_frame(frame(1'b1, 640, 0, -32768));
    send_frame(frame(1'b1, 0, 1023, 32767));
    send_frame(frame(1'b1, 511, 512, -1));
    // target just right of centre, spin goes clockwise
    send_frame(frame(1'b1, 321, 0, 0));
    send_lost(6);
    send_frame(frame(1'b1, 100, 0, 0));
    send_lost(6);
    drain();
  endtask

  task automatic test_window_inversion();
    write_reg(vac_pkg::REG_NARROW_WINDOW, 16'd200);
    write_reg(vac_pkg::REG_WIDE_WINDOW, 16'd40);
    send_frame(frame(1'b1, 380, 10, 0));
    send_frame(frame(1'b1, 420, 10, 0));
    send_frame(frame(1'b1, 600, 10, 0));
    send_frame(frame(1'b1, 320, 10, 0));
    drain();
  endtask

  task automatic test_config_extremes();
    write_all_regs(16'h0000);
    send_frame(frame(1'b1, 320, 0, 0));
    send_frame(frame(1'b1, 0, 1023, 0));
    send_lost(2);
    drain();
    write_all_regs(16'hFFFF);
    send_frame(frame(1'b1, 320, 1023, 0));
    send_frame(frame(1'b1, 0, 1023, 0));
    drain();
    write_reg(vac_pkg::REG_NARROW_WINDOW, 16'd0);
    write_reg(vac_pkg::REG_WIDE_WINDOW, 16'd0);
    send_frame(frame(1'b1, 0, 5, 0));
    repeat (3) send_frame(frame(1'b1, 1023, 5, 0));
    repeat (3) send_frame(frame(1'b1, 0, 5, 0));
    send_lost(3);
    drain();
  endtask

  task automatic test_counter_saturation();
    write_reg(vac_pkg::REG_STOP_HEIGHT, 16'd500);
    write_reg(vac_pkg::REG_TURN_GAIN, 16'd1049);
    write_reg(vac_pkg::REG_SLEW_STEP, 16'd205);
    write_reg(vac_pkg::REG_SEARCH_TURN_RATE, 16'd1434);
    write_reg(vac_pkg::REG_DRIVE_SPEED, 16'd3277);
    write_reg(vac_pkg::REG_NARROW_WINDOW, 16'd10);
    write_reg(vac_pkg::REG_WIDE_WINDOW, 16'd80);
    write_reg(vac_pkg::REG_LOST_LIMIT, 16'd254);
    send_lost(1);
    repeat (256) send_frame(frame(1'b1, 320, 100, 0));
    repeat (4) send_frame(frame(1'b1, 320, 1000, 0));
    send_lost(257);
    drain();
  endtask

  task automatic run_episode_frame();
    send_frame(frame(1'b1, $urandom_range(280, 360), $urandom_range(0, 1023),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(1, 65535) : 0));
  endtask

  task automatic test_backpressure();
    bit saved;
    saved   = idle_on;
    idle_on = 1'b0;
    hold_req = 60;
    repeat (40) run_episode_frame();
    idle_on = saved;
    drain();
  endtask

  task automatic test_random_phases(input int n_phases, input int per_phase);
    int start;
    repeat (n_phases) begin
      write_reg(vac_pkg::REG_STOP_HEIGHT, pick_value(vac_pkg::REG_STOP_HEIGHT));
      write_reg(vac_pkg::REG_TURN_GAIN, pick_value(vac_pkg::REG_TURN_GAIN));
      write_reg(vac_pkg::REG_SLEW_STEP, pick_value(vac_pkg::REG_SLEW_STEP));
      write_reg(vac_pkg::REG_SEARCH_TURN_RATE, pick_value(vac_pkg::REG_SEARCH_TURN_RATE));
      write_reg(vac_pkg::REG_DRIVE_SPEED, pick_value(vac_pkg::REG_DRIVE_SPEED));
      write_reg(vac_pkg::REG_NARROW_WINDOW, pick_value(vac_pkg::REG_NARROW_WINDOW));
      write_reg(vac_pkg::REG_WIDE_WINDOW, pick_value(vac_pkg::REG_WIDE_WINDOW));
      write_reg(vac_pkg::REG_LOST_LIMIT, pick_value(vac_pkg::REG_LOST_LIMIT));
      start = frames_sent;
      while (frames_sent - start < per_phase) begin
        if ($urandom_range(0, 9) < 7) begin
          run_episode();
        end else begin
          repeat ($urandom_range(1, 5))
            send_frame(frame(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                             $urandom_range(0, 1023), $urandom_range(0, 65535)));
        end
      end
      drain();
    end
  endtask

  // receiver: random short stalls, long hold-off on request
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready  = 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    vac_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("unexpected command item", 1, 0);
      end else begin
        want = pending_cmds.pop_front();
        if (out_turn_rate !== want.turn_rate)
          report_mismatch("turn_rate", out_turn_rate, want.turn_rate);
        if (out_forward_speed !== want.forward_speed)
          report_mismatch("forward_speed", out_forward_speed, want.forward_speed);
        if (out_crab_direction !== want.crab_direction)
          report_mismatch("crab_direction", out_crab_direction, want.crab_direction);
        if (out_goal_reached !== want.goal_reached)
          report_mismatch("goal_reached", out_goal_reached, want.goal_reached);
        if (want.goal_reached) goals_seen++;
        cmds_checked++;
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_valid           = 1'b0;
    in_target_found    = 1'b0;
    in_target_center_x = '0;
    in_box_height      = '0;
    in_avoid_direction = '0;
    fail_count         = 0;
    cycle_count        = 0;
    frames_sent        = 0;
    cmds_checked       = 0;
    goals_seen         = 0;
    spins_predicted    = 0;
    in_stalls          = 0;
    hold_req           = 0;
    idle_on            = 1'b1;
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(posedge clk);

    test_reset_defaults();
    test_window_inversion();
    test_config_extremes();
    test_counter_saturation();
    test_backpressure();
    test_random_phases(4, 100);
    idle_on = 1'b0;
    test_random_phases(1, 100);

    drain();
    repeat (10) @(posedge clk);
    $display("ran %0d frames, checked %0d commands: %0d goal flags, %0d search spins",
             frames_sent, cmds_checked, goals_seen, spins_predicted);
    $display("input held off for %0d cycles, %0d mismatches", in_stalls, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
